// ----- hw/rtl/fbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Fuzzy balance controller package
// Shared constants, rule tables and the serial divider handshake types.
// ----------------------------------------------------------------------------
package fbc_pkg;

    // Fuzzy set and rule counts.
    localparam int NSETS  = 5;
    localparam int NRULES = 25;
    localparam int SET_W  = 3;
    localparam int RULE_W = 5;

    // Q1.15 unity and membership width (0 to 32768).
    localparam int Q_ONE = 32768;
    localparam int MU_W  = 16;

    // Output point position width (covers +/-10 * 255).
    localparam int P_W = 13;

    // Numerator step between two neighboring output points.
    localparam int STEP_NUM = 20 * Q_ONE;

    // Default number of output points.
    localparam int OUTPUT_POINTS_DEF = 64;

    // Serial divider widths.
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;
    localparam int DIV_QW = 16;
    localparam int DIV_CW = 5;

    // Triangle breakpoints in tenths (inputs) or whole units (output).
    localparam int TRI_LO  [NSETS] = '{-10, -6, -2, 0, 4};
    localparam int TRI_MID [NSETS] = '{ -7, -3,  0, 3, 7};
    localparam int TRI_HI  [NSETS] = '{ -4,  0,  2, 6, 10};

    // Rule table: offset set, delta set and output set of each rule.
    localparam logic [SET_W-1:0] RULE_OFF [NRULES] = '{
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
    localparam logic [SET_W-1:0] RULE_DLT [NRULES] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
    localparam logic [SET_W-1:0] RULE_OUT [NRULES] = '{
        3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3,
        3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd4};

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_QW-1:0] quot;
    } t_div_rsp;

endpackage

// ----- hw/rtl/fuzzy_balance_controller_unit.sv -----
// ----------------------------------------------------------------------------
// Fuzzy balance controller
// Mamdani controller: fuzzifies the left/right offset and its change, fires
// 25 min-rules, max-aggregates the clipped output sets over the output
// points and returns the centroid in 1/1024 units.
//
//   Channel | Direction | Payload
//   s_axis  | in        | tdata[15:0] left_prob, tdata[31:16] right_prob
//   m_axis  | out       | tdata[14:0] correction, tdata[15] no_rule_fired
//
// A transaction runs the fuzzification of the ten sets, with a divide for each
// set that holds the value and a skip for each set that does not (at most
// three sets of each input hold a value), then the 25 rules, the output
// points and a tail of drain, scale, divide start, divide and hand-off.
// Reset clears the stored offset and all control state.
// A new input is taken in idle even while a result waits on m_axis; a result
// that is still waiting holds the next one in its last state.
// ----------------------------------------------------------------------------
module fuzzy_balance_controller_unit #(
    parameter int OUTPUT_POINTS = fbc_pkg::OUTPUT_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // left_prob [15:0], right_prob [31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // correction [14:0], no_rule_fired [15]
);
    import fbc_pkg::*;

    localparam int DP  = OUTPUT_POINTS - 1;
    localparam int K_W = $clog2(OUTPUT_POINTS);
    localparam int ST_W = 4;

    localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] S_FZ    = 4'd1;
    localparam logic [ST_W-1:0] S_FZW   = 4'd2;
    localparam logic [ST_W-1:0] S_RULE  = 4'd3;
    localparam logic [ST_W-1:0] S_PTS   = 4'd4;
    localparam logic [ST_W-1:0] S_DRAIN = 4'd5;
    localparam logic [ST_W-1:0] S_SCALE = 4'd6;
    localparam logic [ST_W-1:0] S_DIV   = 4'd7;
    localparam logic [ST_W-1:0] S_DIVW  = 4'd8;
    localparam logic [ST_W-1:0] S_DONE  = 4'd9;

    logic [ST_W-1:0]        r_state;
    logic signed [16:0]     r_prev;
    logic signed [16:0]     r_off;
    logic signed [17:0]     r_dlt;
    logic                   r_fsel;
    logic [SET_W-1:0]       r_set;
    logic [RULE_W-1:0]      r_ridx;
    logic [K_W-1:0]         r_k;
    logic [MU_W-1:0]        r_mo [NSETS];
    logic [MU_W-1:0]        r_md [NSETS];
    logic [MU_W-1:0]        r_fmax [NSETS];
    logic                   r_v1, r_v2;
    logic [MU_W-1:0]        r_agg;
    logic signed [P_W-1:0]  r_pp;
    logic signed [29:0]     r_prod;
    logic signed [35:0]     r_num;
    logic [23:0]            r_den;
    logic [31:0]            r_dd;
    logic                   r_neg;
    logic [14:0]            r_res;
    logic                   r_nofire;
    logic                   r_m_valid;
    logic [15:0]            r_m_data;

    logic [15:0]            l_sat, rgt_sat;
    logic signed [16:0]     off_w;
    logic signed [17:0]     val18;
    logic signed [21:0]     v10, bp_a, bp_b, bp_c, fz_num;
    logic                   in_rng;
    logic [2:0]             fz_w;
    logic                   fz_last;
    logic [MU_W-1:0]        fire;
    logic [SET_W-1:0]       out_set;
    logic [MU_W-1:0]        agg;
    logic [MU_W-1:0]        clip;
    logic signed [P_W-1:0]  pt_p;
    logic [NSETS-1:0][MU_W-1:0] mu;
    logic [35:0]            num_abs;
    logic                   pts_init, pts_step;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    // Saturated inputs and their offset.
    assign l_sat   = (s_axis_tdata[15:0]  > 16'(Q_ONE)) ? 16'(Q_ONE) : s_axis_tdata[15:0];
    assign rgt_sat = (s_axis_tdata[31:16] > 16'(Q_ONE)) ? 16'(Q_ONE) : s_axis_tdata[31:16];
    assign off_w   = $signed({1'b0, l_sat}) - $signed({1'b0, rgt_sat});

    // Fuzzification of the current value against the current set.
    assign val18  = r_fsel ? r_dlt : 18'(r_off);
    assign v10    = 22'(val18) * 22'sd10;
    assign bp_a   = 22'(TRI_LO[r_set] * Q_ONE);
    assign bp_b   = 22'(TRI_MID[r_set] * Q_ONE);
    assign bp_c   = 22'(TRI_HI[r_set] * Q_ONE);
    assign in_rng = (v10 >= bp_a) && (v10 <= bp_c);
    assign fz_last = (r_set == SET_W'(NSETS - 1)) && r_fsel;

    always_comb begin
        if (v10 <= bp_b) begin
            fz_num = v10 - bp_a;
            fz_w   = 3'(TRI_MID[r_set] - TRI_LO[r_set]);
        end else begin
            fz_num = bp_c - v10;
            fz_w   = 3'(TRI_HI[r_set] - TRI_MID[r_set]);
        end
    end

    // Rule strength and output set of the current rule.
    always_comb begin
        fire = r_mo[RULE_OFF[r_ridx]];
        if (r_md[RULE_DLT[r_ridx]] < fire) begin
            fire = r_md[RULE_DLT[r_ridx]];
        end
        out_set = RULE_OUT[r_ridx];
    end

    // Aggregate at the current point: max over sets of the clipped value.
    always_comb begin
        agg  = '0;
        clip = '0;
        for (int s = 0; s < NSETS; s++) begin
            clip = (mu[s] < r_fmax[s]) ? mu[s] : r_fmax[s];
            if (clip > agg) begin
                agg = clip;
            end
        end
    end

    assign num_abs = r_num[35] ? 36'(-r_num) : 36'(r_num);

    // Divider requests from fuzzification and from the centroid.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = 48'(fz_num[20:0]);
        div_req.divisor  = 32'(fz_w);
        if (r_state == S_FZ && in_rng) begin
            div_req.start = 1'b1;
        end else if (r_state == S_DIV) begin
            div_req.start    = (r_den != 24'd0);
            div_req.dividend = 48'({num_abs, 11'b0}) + 48'(r_dd);
            div_req.divisor  = {r_dd[30:0], 1'b0};
        end
    end

    assign pts_init = (r_state == S_RULE) && (r_ridx == RULE_W'(NRULES - 1));
    assign pts_step = (r_state == S_PTS);

    fbc_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fbc_outmf #(
        .OUTPUT_POINTS (OUTPUT_POINTS)
    ) u_outmf (
        .i_clk  (i_clk),
        .i_init (pts_init),
        .i_step (pts_step),
        .o_p    (pt_p),
        .o_mu   (mu)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prev    <= '0;
            r_fsel    <= 1'b0;
            r_set     <= '0;
            r_ridx    <= '0;
            r_k       <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_PTS);
            r_v2 <= r_v1;
            // The output register loads in the hand-off state and empties on acceptance.
            if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_prev  <= off_w;
                        r_fsel  <= 1'b0;
                        r_set   <= '0;
                        r_state <= S_FZ;
                    end
                end
                S_FZ, S_FZW: begin
                    if (r_state == S_FZ && in_rng) begin
                        r_state <= S_FZW;
                    end else if (r_state == S_FZ || div_rsp.done) begin
                        if (fz_last) begin
                            r_ridx  <= '0;
                            r_state <= S_RULE;
                        end else begin
                            r_state <= S_FZ;
                            if (r_set == SET_W'(NSETS - 1)) begin
                                r_set  <= '0;
                                r_fsel <= 1'b1;
                            end else begin
                                r_set <= r_set + SET_W'(1);
                            end
                        end
                    end
                end
                S_RULE: begin
                    r_ridx <= r_ridx + RULE_W'(1);
                    if (pts_init) begin
                        r_k     <= '0;
                        r_state <= S_PTS;
                    end
                end
                S_PTS: begin
                    r_k <= r_k + K_W'(1);
                    if (r_k == K_W'(DP)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= (r_den == 24'd0) ? S_DONE : S_DIVW;
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_off <= off_w;
            r_dlt <= 18'(off_w) - 18'(r_prev);
        end
        if (r_state == S_FZ && !in_rng) begin
            if (r_fsel) begin
                r_md[r_set] <= '0;
            end else begin
                r_mo[r_set] <= '0;
            end
        end
        if (r_state == S_FZW && div_rsp.done) begin
            if (r_fsel) begin
                r_md[r_set] <= div_rsp.quot;
            end else begin
                r_mo[r_set] <= div_rsp.quot;
            end
        end
        if (r_state == S_FZ && fz_last && !in_rng) begin
            for (int s = 0; s < NSETS; s++) begin
                r_fmax[s] <= '0;
            end
        end
        if (r_state == S_FZW && fz_last && div_rsp.done) begin
            for (int s = 0; s < NSETS; s++) begin
                r_fmax[s] <= '0;
            end
        end
        if (r_state == S_RULE && fire > r_fmax[out_set]) begin
            r_fmax[out_set] <= fire;
        end
        if (pts_init) begin
            r_num <= '0;
            r_den <= '0;
        end
        if (r_state == S_PTS) begin
            r_agg <= agg;
            r_pp  <= pt_p;
            r_den <= r_den + 24'(agg);
        end
        r_prod <= 30'(r_pp) * $signed(30'({1'b0, r_agg}));
        if (r_v2) begin
            r_num <= r_num + 36'(r_prod);
        end
        if (r_state == S_SCALE) begin
            r_dd <= 32'(r_den) * 32'(DP);
        end
        if (r_state == S_DIV) begin
            r_neg    <= r_num[35];
            r_res    <= '0;
            r_nofire <= (r_den == 24'd0);
        end
        if (r_state == S_DIVW && div_rsp.done) begin
            r_res <= r_neg ? (15'd0 - div_rsp.quot[14:0]) : div_rsp.quot[14:0];
        end
        if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
            r_m_data <= {r_nofire, r_res};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef ASSERT_OFF
    // The divider is never asked to start while it is still working.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A result without any fired rule carries a zero correction.
    a_nofire_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[15]) |-> (m_axis_tdata[14:0] == 15'd0))
        else $error("no_rule_fired with nonzero correction");

    // The correction stays within plus and minus ten.
    a_corr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) <= 15'sd10240 &&
                           $signed(m_axis_tdata[14:0]) >= -15'sd10240))
        else $error("correction out of range");

    // An accepted transaction always leaves idle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("still ready after accepting a transaction");
`endif

endmodule

// ----- hw/rtl/fbc_serdiv.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, for quotients below 2^16.
// ----------------------------------------------------------------------------
module fbc_serdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbc_pkg::t_div_req i_req,
    output fbc_pkg::t_div_rsp o_rsp
);
    import fbc_pkg::*;

    logic [DIV_NW-1:0] r_rem;
    logic [DIV_NW-1:0] r_dsr;
    logic [DIV_QW-1:0] r_quot;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              ge;

    assign ge = (r_rem >= r_dsr);

    // Control: bit counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shifted divisor walks right, quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem  <= i_req.dividend;
            r_dsr  <= DIV_NW'(i_req.divisor) << (DIV_QW - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_dsr  <= r_dsr >> 1;
            r_quot <= {r_quot[DIV_QW-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- hw/rtl/fbc_outmf.sv -----
// ----------------------------------------------------------------------------
// Output membership tracker
// Walks the output points and keeps each output triangle's edge values as
// exact floor quotients, updated by a constant step and one remainder fix.
// ----------------------------------------------------------------------------
module fbc_outmf #(
    parameter int OUTPUT_POINTS = fbc_pkg::OUTPUT_POINTS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_init,
    input  logic                                            i_step,
    output logic signed [fbc_pkg::P_W-1:0]                  o_p,
    output logic [fbc_pkg::NSETS-1:0][fbc_pkg::MU_W-1:0]    o_mu
);
    import fbc_pkg::*;

    localparam int DP = OUTPUT_POINTS - 1;
    localparam int Q_W = 21;
    localparam int R_W = 12;

    logic signed [P_W-1:0] r_p;

    // Point position p = 20k - 10D.
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_p <= P_W'(-10 * DP);
        end else if (i_step) begin
            r_p <= r_p + P_W'(20);
        end
    end

    assign o_p = r_p;

    for (genvar s = 0; s < NSETS; s++) begin : g_set
        localparam int A    = TRI_LO[s];
        localparam int B    = TRI_MID[s];
        localparam int C    = TRI_HI[s];
        localparam int WR   = B - A;
        localparam int WF   = C - B;
        localparam int NR0  = (-10 - A) * Q_ONE;
        localparam int QR0  = -((-NR0 + WR - 1) / WR);
        localparam int RR0  = DP * (NR0 - QR0 * WR);
        localparam int DENR = WR * DP;
        localparam int QSR  = STEP_NUM / DENR;
        localparam int RSR  = STEP_NUM % DENR;
        localparam int NF0  = (C + 10) * Q_ONE;
        localparam int QF0  = NF0 / WF;
        localparam int RF0  = DP * (NF0 - QF0 * WF);
        localparam int DENF = WF * DP;
        localparam int QSF  = STEP_NUM / DENF;
        localparam int RSF  = STEP_NUM % DENF;
        localparam int PA   = A * DP;
        localparam int PB   = B * DP;
        localparam int PC   = C * DP;

        logic signed [Q_W-1:0] r_qr, r_qf, n_qr, n_qf;
        logic signed [R_W-1:0] r_rr, r_rf, n_rr, n_rf;

        // Rising edge grows, falling edge shrinks by the same step.
        always_comb begin
            n_rr = r_rr + R_W'(RSR);
            n_qr = r_qr + Q_W'(QSR);
            if (n_rr >= R_W'(DENR)) begin
                n_rr = n_rr - R_W'(DENR);
                n_qr = n_qr + Q_W'(1);
            end
            n_rf = r_rf - R_W'(RSF);
            n_qf = r_qf - Q_W'(QSF);
            if (n_rf < R_W'(0)) begin
                n_rf = n_rf + R_W'(DENF);
                n_qf = n_qf - Q_W'(1);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_init) begin
                r_qr <= Q_W'(QR0);
                r_rr <= R_W'(RR0);
                r_qf <= Q_W'(QF0);
                r_rf <= R_W'(RF0);
            end else if (i_step) begin
                r_qr <= n_qr;
                r_rr <= n_rr;
                r_qf <= n_qf;
                r_rf <= n_rf;
            end
        end

        // Pick the edge that covers the current point.
        always_comb begin
            if (r_p < P_W'(PA) || r_p > P_W'(PC)) begin
                o_mu[s] = '0;
            end else if (r_p <= P_W'(PB)) begin
                o_mu[s] = r_qr[MU_W-1:0];
            end else begin
                o_mu[s] = r_qf[MU_W-1:0];
            end
        end
    end

endmodule
